/* rtl/tgh_pkg.sv */
`default_nettype none

package tgh_pkg;

    // Channel count the per-channel word stores are sized for.
    localparam int TGH_CHANNELS = 32;

    // Slots per channel in each word store.
    localparam int WIDE_SLOTS   = 8;
    localparam int NARROW_SLOTS = 16;

    typedef enum logic [1:0] {
        ACT_READ      = 2'd0,
        ACT_WRITE     = 2'd1,
        ACT_ROM_RET   = 2'd2,
        ACT_VOICE_END = 2'd3
    } t_action;

    // Bus register addresses with a fixed meaning.
    localparam logic [5:0] ADDR_MASK_LAST = 6'h03;
    localparam logic [5:0] ADDR_ROM_HI    = 6'h21;
    localparam logic [5:0] ADDR_ROM_MID   = 6'h22;
    localparam logic [5:0] ADDR_ROM_LO    = 6'h23;
    localparam logic [5:0] ADDR_HOLD_HI   = 6'h39;
    localparam logic [5:0] ADDR_HOLD_MID  = 6'h3a;
    localparam logic [5:0] ADDR_HOLD_LO   = 6'h3b;
    localparam logic [5:0] ADDR_STATUS    = 6'h3c;
    localparam logic [5:0] ADDR_MODE_B    = 6'h3d;
    localparam logic [5:0] ADDR_CHAN_SEL  = 6'h3e;
    localparam logic [5:0] ADDR_ROM_DATA  = 6'h3f;

    // One accepted bus word as held in the input register.
    typedef struct packed {
        t_action     action;
        logic [5:0]  address;
        logic [7:0]  data;
        logic [4:0]  channel;
    } t_item;

    // Access request from the register file to the word stores.
    typedef struct packed {
        logic        wide_we;
        logic        narrow_we;
        logic        wide_re;
        logic        narrow_re;
        logic [4:0]  chan;
        logic [3:0]  slot;
        logic [19:0] wdata;
    } t_store_req;

endpackage

`default_nettype wire

/* rtl/tgh_store.sv */
`default_nettype none

module tgh_store #(
    parameter int CHANNELS = tgh_pkg::TGH_CHANNELS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tgh_pkg::t_store_req i_req,
    output logic [19:0]             o_rd_data,
    output logic                    o_clearing
);
    import tgh_pkg::*;

    localparam int WDEPTH = CHANNELS * WIDE_SLOTS;
    localparam int NDEPTH = CHANNELS * NARROW_SLOTS;
    localparam int WAW    = $clog2(WDEPTH);
    localparam int NAW    = $clog2(NDEPTH);

    logic [19:0] r_wide_mem   [WDEPTH];
    logic [15:0] r_narrow_mem [NDEPTH];

    logic [NAW-1:0] r_clr_cnt;
    logic           r_clearing;
    logic [19:0]    r_wide_q;
    logic [15:0]    r_narrow_q;
    logic           r_sel_narrow;

    logic [WAW-1:0] widx;
    logic [NAW-1:0] nidx;
    logic           clr_wide;

    assign widx     = WAW'({i_req.chan, i_req.slot[2:0]});
    assign nidx     = NAW'({i_req.chan, i_req.slot});
    assign clr_wide = ({1'b0, r_clr_cnt} < (NAW + 1)'(WDEPTH));

    // Sweep both stores to zero once after reset, one entry per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt  <= '0;
            r_clearing <= 1'b1;
        end else if (r_clearing) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == NAW'(NDEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_narrow_mem[r_clr_cnt] <= '0;
            if (clr_wide) begin
                r_wide_mem[r_clr_cnt[WAW-1:0]] <= '0;
            end
        end else begin
            if (i_req.wide_we) begin
                r_wide_mem[widx] <= i_req.wdata;
            end
            if (i_req.narrow_we) begin
                r_narrow_mem[nidx] <= i_req.wdata[15:0];
            end
        end
        if (i_req.wide_re) begin
            r_wide_q <= r_wide_mem[widx];
        end
        if (i_req.narrow_re) begin
            r_narrow_q <= r_narrow_mem[nidx];
        end
        if (i_req.wide_re || i_req.narrow_re) begin
            r_sel_narrow <= i_req.narrow_re;
        end
    end

    assign o_rd_data  = r_sel_narrow ? {4'h0, r_narrow_q} : r_wide_q;
    assign o_clearing = r_clearing;

endmodule

`default_nettype wire

/* rtl/tgh_regs.sv */
`default_nettype none

module tgh_regs #(
    parameter int CHANNELS = tgh_pkg::TGH_CHANNELS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_item_valid,
    input  wire tgh_pkg::t_item      i_item,
    input  wire logic [19:0]         i_rd_data,
    output tgh_pkg::t_store_req      o_req,
    output logic                     o_valid,
    output logic [7:0]               o_read_data,
    output logic                     o_rom_request,
    output logic [2:0]               o_rom_bank,
    output logic [23:0]              o_rom_address,
    output logic                     o_irq_level,
    output logic [27:0]              o_active_voices
);
    import tgh_pkg::*;

    function automatic logic is_wide(input logic [5:0] a);
        return (a >= 6'h04 && a < 6'h10) || (a >= 6'h24 && a < 6'h30);
    endfunction

    function automatic logic is_narrow(input logic [5:0] a);
        return (a >= 6'h10 && a < 6'h20) || (a >= 6'h30 && a < 6'h38);
    endfunction

    logic [27:0] r_pending,   n_pending;
    logic [27:0] r_committed, n_committed;
    logic        r_upd_flag,  n_upd_flag;
    logic [23:0] r_fetch,     n_fetch;
    logic [7:0]  r_rom_latch, n_rom_latch;
    logic        r_mode_b5,   n_mode_b5;
    logic [4:0]  r_chan_sel,  n_chan_sel;
    logic [19:0] r_assembly,  n_assembly;
    logic [19:0] r_holding;
    logic        r_load_pend, n_load_pend;
    logic        r_load_zero, n_load_zero;
    logic        r_irq_pend,  n_irq_pend;
    logic [4:0]  r_irq_src,   n_irq_src;

    logic        r_valid;
    logic [7:0]  r_read_data, n_read_data;
    logic        r_rom_req,   n_rom_req;
    logic [2:0]  r_rom_bank,  n_rom_bank;
    logic [23:0] r_rom_addr,  n_rom_addr;
    logic        r_irq_out;
    logic [27:0] r_active;

    logic [19:0] hold_eff;
    logic        chan_ok;
    logic [5:0]  a;
    logic [7:0]  d;
    logic [3:0]  wslot;
    logic [3:0]  nslot;

    // A store read lands in the cycle after the request; take it straight from the store then.
    assign hold_eff = r_load_pend ? (r_load_zero ? 20'h0 : i_rd_data) : r_holding;
    assign chan_ok  = ({1'b0, r_chan_sel} < 6'(CHANNELS));
    assign a        = i_item.address;
    assign d        = i_item.data;
    assign wslot    = {1'b0, ~a[3], ~a[2], a[5]};
    assign nslot    = {a[5], a[3:1]};

    always_comb begin
        n_pending   = r_pending;
        n_committed = r_committed;
        n_upd_flag  = r_upd_flag;
        n_fetch     = r_fetch;
        n_rom_latch = r_rom_latch;
        n_mode_b5   = r_mode_b5;
        n_chan_sel  = r_chan_sel;
        n_assembly  = r_assembly;
        n_load_pend = 1'b0;
        n_load_zero = 1'b0;
        n_irq_pend  = r_irq_pend;
        n_irq_src   = r_irq_src;
        n_read_data = 8'h00;
        n_rom_req   = 1'b0;
        n_rom_bank  = 3'd0;
        n_rom_addr  = 24'h0;
        o_req       = '0;
        o_req.chan  = r_chan_sel;

        if (i_item_valid) begin
            case (i_item.action)
                ACT_READ: begin
                    if (a <= ADDR_MASK_LAST) begin
                        if (r_upd_flag) begin
                            n_committed = r_pending;
                        end
                        n_upd_flag = 1'b0;
                    end else if (a == ADDR_STATUS || a == ADDR_CHAN_SEL) begin
                        if (a == ADDR_CHAN_SEL) begin
                            n_irq_pend = 1'b0;
                        end
                        n_read_data = {2'b00, r_upd_flag, r_irq_src};
                    end else if (a == ADDR_ROM_DATA) begin
                        n_read_data = r_rom_latch;
                    end else if (is_wide(a)) begin
                        if (a[1:0] == 2'd1) begin
                            n_load_pend   = 1'b1;
                            n_load_zero   = !chan_ok;
                            o_req.wide_re = chan_ok;
                            o_req.slot    = wslot;
                        end
                    end else if (is_narrow(a)) begin
                        if (!a[0]) begin
                            n_load_pend     = 1'b1;
                            n_load_zero     = !chan_ok;
                            o_req.narrow_re = chan_ok;
                            o_req.slot      = nslot;
                        end
                    end else if (a == ADDR_HOLD_HI) begin
                        n_read_data = {4'h0, hold_eff[19:16]};
                    end else if (a == ADDR_HOLD_MID) begin
                        n_read_data = hold_eff[15:8];
                    end else if (a == ADDR_HOLD_LO) begin
                        n_read_data = hold_eff[7:0];
                    end
                end
                ACT_WRITE: begin
                    if (a <= ADDR_MASK_LAST) begin
                        case (a[1:0])
                            2'd0:    n_pending[27:24] = d[3:0];
                            2'd1:    n_pending[23:16] = d;
                            2'd2:    n_pending[15:8]  = d;
                            default: n_pending[7:0]   = d;
                        endcase
                        n_upd_flag = 1'b1;
                    end else if (a == ADDR_ROM_HI) begin
                        n_fetch[23:16] = d;
                    end else if (a == ADDR_ROM_MID) begin
                        n_fetch[15:8] = d;
                    end else if (a == ADDR_ROM_LO) begin
                        n_fetch[7:0] = d;
                        n_rom_req    = 1'b1;
                        n_rom_addr   = n_fetch;
                        n_rom_bank   = r_mode_b5 ? n_fetch[23:21] : n_fetch[21:19];
                    end else if (a == ADDR_MODE_B) begin
                        n_mode_b5 = d[5];
                    end else if (a == ADDR_CHAN_SEL) begin
                        n_chan_sel = d[4:0];
                    end else if (is_wide(a)) begin
                        case (a[1:0])
                            2'd1:    n_assembly[19:16] = d[3:0];
                            2'd2:    n_assembly[15:8]  = d;
                            2'd3: begin
                                n_assembly[7:0] = d;
                                o_req.wide_we   = chan_ok;
                                o_req.slot      = wslot;
                                o_req.wdata     = n_assembly;
                            end
                            default: ;
                        endcase
                    end else if (is_narrow(a)) begin
                        if (!a[0]) begin
                            n_assembly[15:8] = d;
                        end else begin
                            n_assembly[7:0] = d;
                            o_req.narrow_we = chan_ok;
                            o_req.slot      = nslot;
                            o_req.wdata     = n_assembly;
                        end
                    end
                end
                ACT_ROM_RET: begin
                    n_rom_latch = d;
                end
                default: begin
                    n_irq_pend = 1'b1;
                    n_irq_src  = i_item.channel;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= '0;
            r_committed <= '0;
            r_upd_flag  <= 1'b0;
            r_fetch     <= '0;
            r_rom_latch <= '0;
            r_mode_b5   <= 1'b0;
            r_chan_sel  <= '0;
            r_assembly  <= '0;
            r_holding   <= '0;
            r_load_pend <= 1'b0;
            r_load_zero <= 1'b0;
            r_irq_pend  <= 1'b0;
            r_irq_src   <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_pending   <= n_pending;
            r_committed <= n_committed;
            r_upd_flag  <= n_upd_flag;
            r_fetch     <= n_fetch;
            r_rom_latch <= n_rom_latch;
            r_mode_b5   <= n_mode_b5;
            r_chan_sel  <= n_chan_sel;
            r_assembly  <= n_assembly;
            r_holding   <= hold_eff;
            r_load_pend <= n_load_pend;
            r_load_zero <= n_load_zero;
            r_irq_pend  <= n_irq_pend;
            r_irq_src   <= n_irq_src;
            r_valid     <= i_item_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_read_data <= n_read_data;
        r_rom_req   <= n_rom_req;
        r_rom_bank  <= n_rom_bank;
        r_rom_addr  <= n_rom_addr;
        r_irq_out   <= n_irq_pend;
        r_active    <= n_committed & n_pending;
    end

    assign o_valid         = r_valid;
    assign o_read_data     = r_read_data;
    assign o_rom_request   = r_rom_req;
    assign o_rom_bank      = r_rom_bank;
    assign o_rom_address   = r_rom_addr;
    assign o_irq_level     = r_irq_out;
    assign o_active_voices = r_active;

endmodule

`default_nettype wire

/* rtl/tone_generator_host_register_port.sv */
`default_nettype none

// Host register port of the sample player. Raise start with a bus word on
// i_action/i_address/i_data/i_channel; it is taken at any clock edge where
// busy is low, and a new word may follow at every edge. Each word yields one
// result, shown for exactly one cycle with o_result_valid high, once it has
// passed the input register and then decode and register update into the
// result register. The result cannot be held off, so capture it on that
// cycle. After reset, busy stays high while both word stores are swept to
// zero, one narrow-store entry per cycle with the wide store cleared alongside.
// o_irq_level and o_active_voices reflect the state after the word; the ROM
// fetch fields are zero unless o_rom_request is set.

module tone_generator_host_register_port #(
    parameter int CHANNELS = tgh_pkg::TGH_CHANNELS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_action,
    input  wire logic [5:0]  i_address,
    input  wire logic [7:0]  i_data,
    input  wire logic [4:0]  i_channel,
    output logic             o_result_valid,
    output logic [7:0]       o_read_data,
    output logic             o_rom_request,
    output logic [2:0]       o_rom_bank,
    output logic [23:0]      o_rom_address,
    output logic             o_irq_level,
    output logic [27:0]      o_active_voices
);
    import tgh_pkg::*;

    t_item      r_item;
    logic       r_item_valid;
    t_store_req store_req;
    logic [19:0] store_rd;
    logic       clearing;

    // Hold the accepted word in the input register ahead of decode.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else begin
            r_item_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item.action  <= t_action'(i_action);
        r_item.address <= i_address;
        r_item.data    <= i_data;
        r_item.channel <= i_channel;
    end

    // No word is taken while the stores are still being cleared.
    assign busy = clearing;

    tgh_regs #(
        .CHANNELS (CHANNELS)
    ) u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_valid    (r_item_valid),
        .i_item          (r_item),
        .i_rd_data       (store_rd),
        .o_req           (store_req),
        .o_valid         (o_result_valid),
        .o_read_data     (o_read_data),
        .o_rom_request   (o_rom_request),
        .o_rom_bank      (o_rom_bank),
        .o_rom_address   (o_rom_address),
        .o_irq_level     (o_irq_level),
        .o_active_voices (o_active_voices)
    );

    tgh_store #(
        .CHANNELS (CHANNELS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (store_req),
        .o_rd_data  (store_rd),
        .o_clearing (clearing)
    );

endmodule

`default_nettype wire

/* rtl/tgh_check.sv */
`default_nettype none

module tgh_check (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_result_valid,
    input wire logic        o_rom_request,
    input wire logic [2:0]  o_rom_bank,
    input wire logic [23:0] o_rom_address
);

    // Every accepted word produces its result once it has passed the input and result registers.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_result_valid)
        else $error("accepted word produced no result");

    // No result appears without an earlier accepted word.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start && !busy, 2))
        else $error("result without an accepted word");

    // Fetch fields stay zero unless a fetch is issued.
    a_fetch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_rom_request) |-> (o_rom_address == 24'h0 && o_rom_bank == 3'd0))
        else $error("fetch fields set without a fetch");

    // Busy only comes back through reset.
    a_busy_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(!i_rst_n))
        else $error("busy rose outside reset");

endmodule

bind tone_generator_host_register_port tgh_check u_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_rom_request  (o_rom_request),
    .o_rom_bank     (o_rom_bank),
    .o_rom_address  (o_rom_address)
);

`default_nettype wire
